FILE: design/sdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_pkg: shared types and constants of the sector disk controller
// Window map, command codes and the decoded operation that travels from the
// front end through the queue to the back end.
// ----------------------------------------------------------------------------
package sdc_pkg;

  // Default geometry
  localparam int SECTOR_BYTES_DEF = 512;
  localparam int DISK_BLOCKS_DEF  = 64;

  // Bus window
  localparam int             ADDR_W     = 16;
  localparam logic [15:0]    WIN_BASE   = 16'hD000;
  localparam int             WIN_SIZE   = 'h400;
  localparam int             OFF_W      = $clog2(WIN_SIZE);
  localparam logic [OFF_W-1:0] OFF_BLK_LAST = OFF_W'('h003);
  localparam logic [OFF_W-1:0] OFF_ERR      = OFF_W'('h007);
  localparam logic [OFF_W-1:0] OFF_CMD      = OFF_W'('h00B);
  localparam logic [OFF_W-1:0] OFF_BUF      = OFF_W'('h200);
  // Widest buffer index the upper half of the window can address
  localparam int             BUF_IDX_W  = $clog2(WIN_SIZE - 'h200);

  // Bus access kinds
  localparam logic OPC_READ  = 1'b0;
  localparam logic OPC_WRITE = 1'b1;

  // Command codes
  localparam logic [7:0] CMD_LOAD  = 8'h00;
  localparam logic [7:0] CMD_STORE = 8'h01;

  // Error code for a block beyond the disk
  localparam logic [7:0] ERR_RANGE = 8'h01;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Decoded target of an access
  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_BLK  = 3'd1,
    KIND_ERR  = 3'd2,
    KIND_CMD  = 3'd3,
    KIND_BUF  = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic                 is_write;
    logic [1:0]           sel;
    logic [BUF_IDX_W-1:0] buf_idx;
    logic [7:0]           data;
  } op_t;

endpackage

FILE: design/sdc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sdc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_queue: short FIFO of decoded operations
// Decouples the decoding front end from the executing back end.
// ----------------------------------------------------------------------------
module sdc_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  sdc_pkg::op_t push_op,
  input  logic         pop,
  output logic         full,
  output logic         not_empty,
  output sdc_pkg::op_t head_op
);
  import sdc_pkg::*;

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_op   = entries[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/sdc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_front: request acceptance and address decode
// Takes bus transactions, classifies them against the window map and
// pushes a decoded operation into the queue.
// ----------------------------------------------------------------------------
module sdc_front #(
  parameter int SECTOR_BYTES = sdc_pkg::SECTOR_BYTES_DEF
) (
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic                       opcode,
  input  logic [sdc_pkg::ADDR_W-1:0] bus_address,
  input  logic [7:0]                 write_byte,
  input  logic                       clearing,
  input  logic                       q_full,
  output logic                       push,
  output sdc_pkg::op_t               push_op
);
  import sdc_pkg::*;

  logic             in_win;
  logic [OFF_W-1:0] off;
  logic [OFF_W-1:0] buf_off;

  assign req_ready = !q_full && !clearing;
  assign push      = req_valid && req_ready;

  assign in_win  = (bus_address >= WIN_BASE) &&
                   (bus_address < (WIN_BASE + ADDR_W'(WIN_SIZE)));
  assign off     = OFF_W'(bus_address - WIN_BASE);
  assign buf_off = off - OFF_BUF;

  // Classify the access
  always_comb begin
    push_op.is_write = (opcode == OPC_WRITE);
    push_op.sel      = off[1:0];
    push_op.buf_idx  = buf_off[BUF_IDX_W-1:0];
    push_op.data     = write_byte;
    push_op.kind     = KIND_NONE;
    if (in_win) begin
      if (off <= OFF_BLK_LAST) begin
        push_op.kind = KIND_BLK;
      end else if (off == OFF_ERR) begin
        push_op.kind = KIND_ERR;
      end else if (off == OFF_CMD) begin
        push_op.kind = KIND_CMD;
      end else if ((off >= OFF_BUF) && (buf_off < OFF_W'(SECTOR_BYTES))) begin
        push_op.kind = KIND_BUF;
      end
    end
  end

endmodule

FILE: design/sdc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdc_back: operation execution
// Holds the registers, the sector buffer and the disk store, runs the
// clearing pass after reset, streams sectors and drives the response.
// ----------------------------------------------------------------------------
module sdc_back #(
  parameter int SECTOR_BYTES = sdc_pkg::SECTOR_BYTES_DEF,
  parameter int DISK_BLOCKS  = sdc_pkg::DISK_BLOCKS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  sdc_pkg::op_t q_op,
  output logic         q_pop,
  output logic         clearing,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output logic [7:0]   read_byte,
  output logic         accepted
);
  import sdc_pkg::*;

  localparam int DISK_DEPTH = SECTOR_BYTES * DISK_BLOCKS;
  localparam int DADDR_W    = $clog2(DISK_DEPTH);
  localparam int BIDX_W     = $clog2(SECTOR_BYTES);
  localparam int CNT_W      = $clog2(SECTOR_BYTES + 1);
  localparam int BLK_W      = (DISK_BLOCKS > 1) ? $clog2(DISK_BLOCKS) : 1;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_BUFRD = 6'b000100,
    ST_SETUP = 6'b001000,
    ST_LOAD  = 6'b010000,
    ST_STORE = 6'b100000
  } back_state_t;

  back_state_t        state;
  logic [31:0]        block_number;
  logic [7:0]         error_byte;
  logic [7:0]         command_byte;
  logic [DADDR_W-1:0] clr_cnt;
  logic [DADDR_W-1:0] base;
  logic [CNT_W-1:0]   cnt;
  logic               out_free;
  logic               clr_in_buf;
  logic [CNT_W-1:0]   cnt_prev;

  logic               buf_we;
  logic [BIDX_W-1:0]  buf_waddr;
  logic [7:0]         buf_wdata;
  logic [BIDX_W-1:0]  buf_raddr;
  logic [7:0]         buf_rdata;
  logic               disk_we;
  logic [DADDR_W-1:0] disk_waddr;
  logic [7:0]         disk_wdata;
  logic [DADDR_W-1:0] disk_raddr;
  logic [7:0]         disk_rdata;

  assign clearing   = (state == ST_CLEAR);
  assign out_free   = !rsp_valid || rsp_ready;
  assign q_pop      = (state == ST_IDLE) && q_valid && out_free;
  assign clr_in_buf = ({1'b0, clr_cnt} < (DADDR_W + 1)'(SECTOR_BYTES));
  assign cnt_prev   = cnt - CNT_W'(1);

  // Steer the memory ports
  always_comb begin
    buf_we     = 1'b0;
    buf_waddr  = q_op.buf_idx[BIDX_W-1:0];
    buf_wdata  = q_op.data;
    buf_raddr  = q_op.buf_idx[BIDX_W-1:0];
    disk_we    = 1'b0;
    disk_waddr = clr_cnt;
    disk_wdata = '0;
    disk_raddr = base + DADDR_W'(cnt);
    unique case (state)
      ST_CLEAR: begin
        disk_we   = 1'b1;
        buf_we    = clr_in_buf;
        buf_waddr = clr_cnt[BIDX_W-1:0];
        buf_wdata = '0;
      end
      ST_IDLE: begin
        buf_we = q_pop && (q_op.kind == KIND_BUF) && q_op.is_write;
      end
      ST_LOAD: begin
        buf_we    = (cnt != '0);
        buf_waddr = cnt_prev[BIDX_W-1:0];
        buf_wdata = disk_rdata;
      end
      ST_STORE: begin
        buf_raddr  = cnt[BIDX_W-1:0];
        disk_we    = (cnt != '0);
        disk_waddr = base + DADDR_W'(cnt) - DADDR_W'(1);
        disk_wdata = buf_rdata;
      end
      ST_BUFRD, ST_SETUP: begin
      end
      default: begin
      end
    endcase
  end

  // Sequence operations and load the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      cnt          <= '0;
      block_number <= '0;
      error_byte   <= '0;
      command_byte <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_cnt == DADDR_W'(DISK_DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            rsp_valid <= 1'b1;
            read_byte <= '0;
            accepted  <= 1'b1;
            unique case (q_op.kind)
              KIND_NONE: begin
                accepted <= 1'b0;
              end
              KIND_BLK: begin
                if (q_op.is_write) begin
                  block_number[{q_op.sel, 3'b000} +: 8] <= q_op.data;
                end else begin
                  read_byte <= block_number[{q_op.sel, 3'b000} +: 8];
                end
              end
              KIND_ERR: begin
                if (q_op.is_write) begin
                  error_byte <= q_op.data;
                end else begin
                  read_byte <= error_byte;
                end
              end
              KIND_CMD: begin
                if (q_op.is_write) begin
                  error_byte   <= '0;
                  command_byte <= q_op.data;
                  if ((q_op.data == CMD_LOAD) || (q_op.data == CMD_STORE)) begin
                    if (block_number >= 32'(DISK_BLOCKS)) begin
                      error_byte <= ERR_RANGE;
                      accepted   <= 1'b0;
                    end else begin
                      // Hold the response until the sector has moved
                      rsp_valid <= 1'b0;
                      state     <= ST_SETUP;
                    end
                  end
                end else begin
                  read_byte <= command_byte;
                end
              end
              KIND_BUF: begin
                if (!q_op.is_write) begin
                  rsp_valid <= 1'b0;
                  state     <= ST_BUFRD;
                end
              end
              default: begin
                accepted <= 1'b0;
              end
            endcase
          end
        end
        ST_BUFRD: begin
          rsp_valid <= 1'b1;
          read_byte <= buf_rdata;
          accepted  <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_SETUP: begin
          base  <= DADDR_W'(block_number[BLK_W-1:0]) * DADDR_W'(SECTOR_BYTES);
          cnt   <= '0;
          state <= (command_byte == CMD_STORE) ? ST_STORE : ST_LOAD;
        end
        ST_LOAD, ST_STORE: begin
          if (cnt == CNT_W'(SECTOR_BYTES)) begin
            rsp_valid <= 1'b1;
            read_byte <= '0;
            accepted  <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Sector buffer
  sdc_ram #(
    .WIDTH (8),
    .DEPTH (SECTOR_BYTES)
  ) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // Disk store
  sdc_ram #(
    .WIDTH (8),
    .DEPTH (DISK_DEPTH)
  ) u_disk_ram (
    .clk   (clk),
    .we    (disk_we),
    .waddr (disk_waddr),
    .wdata (disk_wdata),
    .raddr (disk_raddr),
    .rdata (disk_rdata)
  );

endmodule

FILE: design/sector_disk_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_disk_controller: byte-wide memory-mapped disk controller
//
//   channel   handshake              payload
//   request   req_valid / req_ready  opcode, bus_address, write_byte
//   response  rsp_valid / rsp_ready  read_byte, accepted
//
// Register accesses, buffer writes and rejected accesses: one transaction
// per cycle while responses are taken, set by the single execute slot of
// the back end. Buffer reads: the back end passes through ST_BUFRD for the
// registered read of the buffer RAM. Sector commands: ST_SETUP, then
// ST_LOAD or ST_STORE, one byte a cycle between the buffer RAM and the disk RAM.
// After reset a clearing pass zeroes both memories; req_ready stays low
// meanwhile and whenever the queue is full.
// ----------------------------------------------------------------------------
module sector_disk_controller #(
  parameter int SECTOR_BYTES = sdc_pkg::SECTOR_BYTES_DEF,
  parameter int DISK_BLOCKS  = sdc_pkg::DISK_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic                       opcode,
  input  logic [sdc_pkg::ADDR_W-1:0] bus_address,
  input  logic [7:0]                 write_byte,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic [7:0]                 read_byte,
  output logic                       accepted
);
  import sdc_pkg::*;

  logic clearing;
  logic q_full;
  logic push;
  op_t  push_op;
  logic q_valid;
  op_t  q_op;
  logic q_pop;

  // Accept and decode
  sdc_front #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_front (
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .opcode      (opcode),
    .bus_address (bus_address),
    .write_byte  (write_byte),
    .clearing    (clearing),
    .q_full      (q_full),
    .push        (push),
    .push_op     (push_op)
  );

  // Decoded operations in flight
  sdc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_op   (q_op)
  );

  // Execute
  sdc_back #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .DISK_BLOCKS  (DISK_BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .read_byte (read_byte),
    .accepted  (accepted)
  );

endmodule
